// ===== sv/aqrr_pkg.sv =====
// package of the adaptive quantum round robin scheduler: sizes, codes and item types
package aqrr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;

  // operation codes
  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_FINISH  = 2'd0;
  localparam logic [1:0] KIND_REQUEUE = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CAP       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = CFG_IDX_W'(3);

  // configuration reset values
  localparam logic [7:0] STEP_UP_RST   = 8'd10;
  localparam logic [7:0] STEP_DOWN_RST = 8'd5;
  localparam logic [7:0] CAP_RST       = 8'd100;
  localparam logic [7:0] FLOOR_RST     = 8'd5;

  typedef struct packed {
    logic        op;
    logic [7:0]  proc_id;
    logic [15:0] cpu_units;
    logic [15:0] io_units;
    logic [7:0]  start_quantum;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  who;
    logic [31:0] event_time;
    logic        did_io;
    logic [7:0]  next_quantum;
    logic        final_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] cpu_left;
    logic [15:0] io_left;
    logic [7:0]  quantum;
  } slot_t;

endpackage

// ===== sv/adaptive_quantum_round_robin.sv =====
// top level of the adaptive quantum round robin scheduler
// usage
//   input channel (in_valid_i / in_ready_o / in_data_i): one transfer is either an
//   admit, which appends a process to the tail of the slot ring, or a tick, which
//   retires finished processes at the head, spends one unit of cpu (else of i/o)
//   on the first one left, if any, and advances the time counter
//   output channel (out_valid_o / out_ready_i / out_data_o): finish, requeue and
//   reject events; final_res marks the last event of one input transfer
//   config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): always
//   ready, indexes above the quantum floor register are dropped
// sequence
//   an admit writes its slot from the idle state, a tick on an empty ring only
//   advances time and a rejected admit goes on to the flush state; a tick on a
//   busy ring reads one slot per cycle, unless stalled, until it can flush.
// reset
//   ring empty, time counter zero, quantum registers at their defaults; the slot
//   memory is not cleared, only occupied slots are ever read
// stalls
//   one event waits in the output register and one more in a holding register;
//   the block stops while a held event must move into an output register not yet taken
module adaptive_quantum_round_robin (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  aqrr_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output aqrr_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [aqrr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  localparam int PW = aqrr_pkg::PTR_W;
  localparam int OW = aqrr_pkg::OCC_W;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(aqrr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // quantum registers
  logic [7:0] step_up_q, step_down_q, cap_q, floor_q;

  // control and time state
  logic [1:0]  state_q, state_d;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [31:0] now_q, now_d, slice_q, slice_d;
  logic        io_used_q, io_used_d;

  // one held event, waiting until it is known whether it is the last one
  logic                hold_valid_q, hold_valid_d;
  aqrr_pkg::out_item_t hold_q, hold_d;

  // output register
  logic                out_valid_q, out_valid_d;
  aqrr_pkg::out_item_t out_q, out_d;
  logic                out_free;

  // slot memory ports
  logic            ram_we, ram_re;
  logic [PW-1:0]   ram_waddr, ram_raddr;
  aqrr_pkg::slot_t ram_wdata, entry, run_entry;
  logic [$bits(aqrr_pkg::slot_t)-1:0] ram_rdata;

  // head evaluation
  logic        fin, io_new, expire, new_res, stall;
  logic [31:0] now_n, elapsed;
  logic [8:0]  grow_sum, shrink_lim;
  logic [7:0]  q_grow, q_shrink, q_new;

  aqrr_ram #(
    .WIDTH($bits(aqrr_pkg::slot_t)),
    .DEPTH(aqrr_pkg::QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_up_q   <= aqrr_pkg::STEP_UP_RST;
      step_down_q <= aqrr_pkg::STEP_DOWN_RST;
      cap_q       <= aqrr_pkg::CAP_RST;
      floor_q     <= aqrr_pkg::FLOOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        aqrr_pkg::CFG_STEP_UP:   step_up_q   <= cfg_data_i;
        aqrr_pkg::CFG_STEP_DOWN: step_down_q <= cfg_data_i;
        aqrr_pkg::CFG_CAP:       cap_q       <= cfg_data_i;
        aqrr_pkg::CFG_FLOOR:     floor_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // head slot as read, and the effect of spending one unit on it
  always_comb begin
    entry     = aqrr_pkg::slot_t'(ram_rdata);
    fin       = (entry.cpu_left == 16'd0) && (entry.io_left == 16'd0);
    run_entry = entry;
    if (entry.cpu_left != 16'd0) begin
      run_entry.cpu_left = entry.cpu_left - 16'd1;
    end else begin
      run_entry.io_left = entry.io_left - 16'd1;
    end
    io_new  = io_used_q || (entry.cpu_left == 16'd0);
    now_n   = now_q + 32'd1;
    elapsed = now_n - slice_q;
    expire  = elapsed >= {24'd0, entry.quantum};

    // growth saturates at the cap, shrink at the floor
    grow_sum   = {1'b0, entry.quantum} + {1'b0, step_up_q};
    shrink_lim = {1'b0, floor_q} + {1'b0, step_down_q};
    if (entry.quantum >= cap_q) begin
      q_grow = entry.quantum;
    end else if (grow_sum > {1'b0, cap_q}) begin
      q_grow = cap_q;
    end else begin
      q_grow = grow_sum[7:0];
    end
    if (entry.quantum <= floor_q) begin
      q_shrink = entry.quantum;
    end else if ({1'b0, entry.quantum} < shrink_lim) begin
      q_shrink = floor_q;
    end else begin
      q_shrink = entry.quantum - step_down_q;
    end
    q_new = io_new ? q_shrink : q_grow;

    new_res = fin || expire;
    // a new event needs the held one moved out first
    stall   = new_res && hold_valid_q && !out_free;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    now_d        = now_q;
    slice_d      = slice_q;
    io_used_d    = io_used_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_q;
    ram_wdata    = run_entry;
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.op == aqrr_pkg::OP_ADMIT) begin
            if (occ_q == OW'(aqrr_pkg::QUEUE_DEPTH)) begin
              // ring full, reject
              hold_d.kind         = aqrr_pkg::KIND_REJECT;
              hold_d.who          = in_data_i.proc_id;
              hold_d.event_time   = now_q;
              hold_d.did_io       = 1'b0;
              hold_d.next_quantum = 8'd0;
              hold_d.final_res    = 1'b0;
              hold_valid_d        = 1'b1;
              state_d             = S_FLUSH;
            end else begin
              ram_we             = 1'b1;
              ram_waddr          = tail_q;
              ram_wdata.id       = in_data_i.proc_id;
              ram_wdata.cpu_left = in_data_i.cpu_units;
              ram_wdata.io_left  = in_data_i.io_units;
              ram_wdata.quantum  = in_data_i.start_quantum;
              tail_d             = ring_next(tail_q);
              occ_d              = occ_q + OW'(1);
            end
          end else if (occ_q == '0) begin
            // idle tick
            now_d   = now_n;
            slice_d = now_n;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_q;
            state_d   = S_READ;
          end
        end
      end

      S_READ: begin
        if (!stall) begin
          if (hold_valid_q && new_res) begin
            out_valid_d         = 1'b1;
            out_d               = hold_q;
            out_d.final_res     = 1'b0;
          end
          if (fin) begin
            // retire the head and look at the next one
            hold_d.kind         = aqrr_pkg::KIND_FINISH;
            hold_d.who          = entry.id;
            hold_d.event_time   = now_q;
            hold_d.did_io       = io_used_q;
            hold_d.next_quantum = 8'd0;
            hold_d.final_res    = 1'b0;
            hold_valid_d        = 1'b1;
            io_used_d           = 1'b0;
            slice_d             = now_q;
            head_d              = ring_next(head_q);
            occ_d               = occ_q - OW'(1);
            if (occ_q == OW'(1)) begin
              now_d   = now_n;
              slice_d = now_n;
              state_d = S_FLUSH;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = ring_next(head_q);
            end
          end else begin
            // spend one unit and write the slot back
            ram_we    = 1'b1;
            ram_waddr = head_q;
            now_d     = now_n;
            io_used_d = io_new;
            state_d   = S_FLUSH;
            if (expire) begin
              hold_d.kind         = aqrr_pkg::KIND_REQUEUE;
              hold_d.who          = entry.id;
              hold_d.event_time   = now_n;
              hold_d.did_io       = io_new;
              hold_d.next_quantum = q_new;
              hold_d.final_res    = 1'b0;
              hold_valid_d        = 1'b1;
              io_used_d           = 1'b0;
              slice_d             = now_n;
              ram_wdata.quantum   = q_new;
              // a lone process keeps its slot
              if (occ_q > OW'(1)) begin
                ram_waddr = tail_q;
                tail_d    = ring_next(tail_q);
                head_d    = ring_next(head_q);
              end
            end
          end
        end
      end

      S_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d     = 1'b1;
          out_d           = hold_q;
          out_d.final_res = 1'b1;
          hold_valid_d    = 1'b0;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      occ_q        <= '0;
      now_q        <= '0;
      slice_q      <= '0;
      io_used_q    <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      occ_q        <= occ_d;
      now_q        <= now_d;
      slice_q      <= slice_d;
      io_used_q    <= io_used_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // event payloads
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

endmodule

// ===== sv/aqrr_ram.sv =====
// generic single write port, single read port ram with registered read
module aqrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
